@@ src/edc_pkg.sv @@
// Shared types, register codes and helper functions for the error detection checker.
`default_nettype none

package edc_pkg;

    localparam int FRONT_DEPTH = 4;
    localparam int FRONT_PTR_W = $clog2(FRONT_DEPTH);
    localparam int RES_DEPTH   = 2;
    localparam int RES_PTR_W   = $clog2(RES_DEPTH);
    localparam int DATA_W      = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 6;

    typedef enum logic [1:0] {
        MODE_PARITY   = 2'd0,
        MODE_PARITY2D = 2'd1,
        MODE_CHECKSUM = 2'd2,
        MODE_CRC      = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE        = 3'd0,
        REG_SEG_WIDTH   = 3'd1,
        REG_SEG_COUNT   = 3'd2,
        REG_CRC_DIVISOR = 3'd3,
        REG_CRC_DEGREE  = 3'd4
    } reg_idx_t;

    localparam logic [5:0]  SEG_WIDTH_RST   = 6'd8;
    localparam logic [4:0]  SEG_COUNT_RST   = 5'd4;
    localparam logic [32:0] CRC_DIVISOR_RST = 33'h104C11DB7;
    localparam logic [5:0]  CRC_DEGREE_RST  = 6'd32;

    typedef struct packed {
        mode_t       mode;
        logic [5:0]  seg_width;
        logic [4:0]  seg_count;
        logic [32:0] crc_divisor;
        logic [5:0]  crc_degree;
    } cfg_t;

    typedef struct packed {
        logic data_bit;
        logic last;
    } beat_t;

    typedef struct packed {
        logic        error_found;
        logic [31:0] row_errors;
        logic [31:0] column_errors;
        logic [31:0] check_value;
    } result_t;

    // Clamp a length register to 1..32.
    function automatic logic [5:0] eff_len(input logic [5:0] n);
        logic [5:0] r;
        begin
            if (n == 6'd0)
            begin
                r = 6'd1;
            end
            else if (n > 6'd32)
            begin
                r = 6'd32;
            end
            else
            begin
                r = n;
            end
            return r;
        end
    endfunction

    // Mask of the low n bits, n in 0..32.
    function automatic logic [31:0] low_mask(input logic [5:0] n);
        logic [32:0] m;
        begin
            m = (33'd1 << n) - 33'd1;
            return m[31:0];
        end
    endfunction

endpackage

`default_nettype wire

@@ src/error_detection_checker_top.sv @@
// Top level of the receive-side error detection checker.
`default_nettype none

// The checker takes a message one bit per beat on bit_req, first bit first,
// with last high on the closing bit, and gives one result beat per message.
// All four checks (single parity, two-dimensional parity, ones' complement
// checksum and CRC) run on every bit; the mode register picks which one is
// reported. A four-beat input queue feeds the checking core, which consumes
// one bit per clock unless stalled, so push may stay high every cycle and
// the block sustains one bit per cycle. A result enters a two-beat result
// queue when the core takes its closing bit from the input queue, and sits
// there until popped; the core stalls only when that queue is full and the
// next bit closes a message. The registers (byte addresses 0, 8, 16, 24, 32
// for mode, seg_width, seg_count, crc_divisor, crc_degree) are written over
// the APB-style port; write them only between messages or when no bit is in
// flight, since a change applies from the next bit the core processes.
// Parity2D and checksum ignore bits after the last whole row or word.

module error_detection_checker_top
    import edc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    // message bits
    input  wire logic                  push,
    output logic                       full,
    input  wire logic                  bit_req,
    input  wire logic                  last,
    // results
    output logic                       empty,
    input  wire logic                  pop,
    output logic                       error_found,
    output logic      [DATA_W-1:0]     row_errors,
    output logic      [DATA_W-1:0]     column_errors,
    output logic      [DATA_W-1:0]     check_value
);

    cfg_t    cfg;
    logic    q_valid;
    logic    q_take;
    beat_t   q_beat;
    result_t res;

    // register file
    edc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // accept bits and hold them until the core is ready
    edc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .bit_req (bit_req),
        .last    (last),
        .full    (full),
        .q_valid (q_valid),
        .q_beat  (q_beat),
        .q_take  (q_take)
    );

    // run the checks and queue one result beat per message
    edc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_beat  (q_beat),
        .q_take  (q_take),
        .empty   (empty),
        .pop     (pop),
        .res     (res)
    );

    assign error_found   = res.error_found;
    assign row_errors    = res.row_errors;
    assign column_errors = res.column_errors;
    assign check_value   = res.check_value;

endmodule

`default_nettype wire

@@ src/edc_cfg.sv @@
// APB-style configuration register file for the error detection checker.
`default_nettype none

module edc_cfg
    import edc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    mode_t       mode_reg;
    logic [5:0]  seg_width_reg;
    logic [4:0]  seg_count_reg;
    logic [32:0] crc_divisor_reg;
    logic [5:0]  crc_degree_reg;
    logic        wr_en;
    reg_idx_t    idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_PARITY;
            seg_width_reg   <= SEG_WIDTH_RST;
            seg_count_reg   <= SEG_COUNT_RST;
            crc_divisor_reg <= CRC_DIVISOR_RST;
            crc_degree_reg  <= CRC_DEGREE_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MODE:        mode_reg        <= mode_t'(pwdata[1:0]);
                REG_SEG_WIDTH:   seg_width_reg   <= pwdata[5:0];
                REG_SEG_COUNT:   seg_count_reg   <= pwdata[4:0];
                REG_CRC_DIVISOR: crc_divisor_reg <= pwdata[32:0];
                REG_CRC_DEGREE:  crc_degree_reg  <= pwdata[5:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MODE:        prdata = {62'd0, mode_reg};
            REG_SEG_WIDTH:   prdata = {58'd0, seg_width_reg};
            REG_SEG_COUNT:   prdata = {59'd0, seg_count_reg};
            REG_CRC_DIVISOR: prdata = {31'd0, crc_divisor_reg};
            REG_CRC_DEGREE:  prdata = {58'd0, crc_degree_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.mode        = mode_reg;
    assign cfg.seg_width   = seg_width_reg;
    assign cfg.seg_count   = seg_count_reg;
    assign cfg.crc_divisor = crc_divisor_reg;
    assign cfg.crc_degree  = crc_degree_reg;

endmodule

`default_nettype wire

@@ src/edc_front.sv @@
// Front end: accepts message bits and queues them, marking the closing beat.
`default_nettype none

module edc_front
    import edc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire logic  bit_req,
    input  wire logic  last,
    output logic       full,
    output logic       q_valid,
    output beat_t      q_beat,
    input  wire logic  q_take
);

    beat_t                  mem_reg [FRONT_DEPTH];
    logic [FRONT_PTR_W-1:0] wr_ptr_reg;
    logic [FRONT_PTR_W-1:0] rd_ptr_reg;
    logic [FRONT_PTR_W:0]   count_reg;
    logic [FRONT_PTR_W:0]   count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full    = (count_reg == (FRONT_PTR_W+1)'(FRONT_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_beat  = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_take && q_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= '{data_bit: bit_req, last: last};
        end
    end

endmodule

`default_nettype wire

@@ src/edc_back.sv @@
// Back end: runs all four checks on each bit and queues the result of each message.
`default_nettype none

module edc_back
    import edc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  q_valid,
    input  wire beat_t q_beat,
    output logic       q_take,
    output logic       empty,
    input  wire logic  pop,
    output result_t    res
);

    logic [31:0] crc_rem_reg,  crc_rem_next;
    logic [31:0] checksum_reg, checksum_next;
    logic [31:0] word_shift_reg, word_shift_next;
    logic [5:0]  bis_reg, bis_next;
    logic [5:0]  seg_idx_reg, seg_idx_next;
    logic        run_par_reg, run_par_next;
    logic        row_par_reg, row_par_next;
    logic [31:0] col_par_reg, col_par_next;
    logic [31:0] row_map_reg, row_map_next;

    result_t              res_mem_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] res_wr_reg;
    logic [RES_PTR_W-1:0] res_rd_reg;
    logic [RES_PTR_W:0]   res_cnt_reg;
    logic                 res_full;
    logic                 res_push;
    logic                 res_pop;

    logic [5:0]  w_eff, d_eff, d_m1, limit;
    logic [31:0] wm, dm, colmask;
    logic        b, top, seg_done, in_rows, row_flag;
    logic [31:0] crc_shift, ws_shift, word, rev, col_word, sum_fold;
    logic [32:0] sum33;
    logic [5:0]  bis_inc;
    result_t     res_new;

    assign res_full = (res_cnt_reg == (RES_PTR_W+1)'(RES_DEPTH));
    assign empty    = (res_cnt_reg == '0);
    assign q_take   = q_valid && (!q_beat.last || !res_full);
    assign res_push = q_take && q_beat.last;
    assign res_pop  = pop && !empty;
    assign res      = res_mem_reg[res_rd_reg];

    always_comb
    begin
        w_eff   = eff_len(cfg.seg_width);
        d_eff   = eff_len(cfg.crc_degree);
        d_m1    = d_eff - 6'd1;
        wm      = low_mask(w_eff);
        dm      = low_mask(d_eff);
        colmask = low_mask(w_eff - 6'd1);
        b       = q_beat.data_bit;

        // CRC: long division one bit at a time
        top          = crc_rem_reg[d_m1[4:0]];
        crc_shift    = {crc_rem_reg[30:0], b} & dm;
        crc_rem_next = top ? (crc_shift ^ (cfg.crc_divisor[31:0] & dm)) : crc_shift;

        run_par_next = run_par_reg ^ b;
        ws_shift     = {word_shift_reg[30:0], b};
        bis_inc      = bis_reg + 6'd1;
        seg_done     = (bis_inc >= w_eff);
        word         = ws_shift & wm;

        // ones' complement add with end-around carry
        sum33 = {1'b0, checksum_reg & wm} + {1'b0, word};
        if (sum33 > {1'b0, wm})
        begin
            sum_fold = (sum33[31:0] & wm) + 32'd1;
        end
        else
        begin
            sum_fold = sum33[31:0];
        end

        // first bit of the row is column 0
        for (int i = 0; i < 32; i++)
        begin
            rev[i] = ws_shift[31-i];
        end
        col_word = rev >> (6'd32 - w_eff);

        limit    = {1'b0, cfg.seg_count} + 6'd1;
        in_rows  = (seg_idx_reg < limit);
        row_flag = (seg_idx_reg < {1'b0, cfg.seg_count}) && (row_par_reg ^ b);

        checksum_next   = checksum_reg;
        row_map_next    = row_map_reg;
        col_par_next    = col_par_reg;
        seg_idx_next    = seg_idx_reg;
        word_shift_next = ws_shift;
        row_par_next    = row_par_reg ^ b;
        bis_next        = bis_inc;

        if (seg_done)
        begin
            checksum_next = sum_fold;
            if (in_rows)
            begin
                if (row_flag)
                begin
                    row_map_next = row_map_reg | (32'd1 << seg_idx_reg[4:0]);
                end
                col_par_next = col_par_reg ^ col_word;
                seg_idx_next = seg_idx_reg + 6'd1;
            end
            word_shift_next = '0;
            row_par_next    = 1'b0;
            bis_next        = '0;
        end

        res_new = '0;
        case (cfg.mode)
            MODE_PARITY:
            begin
                res_new.error_found = run_par_next;
            end
            MODE_PARITY2D:
            begin
                res_new.row_errors    = row_map_next;
                res_new.column_errors = col_par_next & colmask;
                res_new.error_found   = (row_map_next != '0) ||
                                        ((col_par_next & colmask) != '0);
            end
            MODE_CHECKSUM:
            begin
                res_new.check_value = ~checksum_next & wm;
                res_new.error_found = ((~checksum_next & wm) != '0);
            end
            default:
            begin
                res_new.check_value = crc_rem_next;
                res_new.error_found = (crc_rem_next != '0);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_rem_reg    <= '0;
            checksum_reg   <= '0;
            word_shift_reg <= '0;
            bis_reg        <= '0;
            seg_idx_reg    <= '0;
            run_par_reg    <= 1'b0;
            row_par_reg    <= 1'b0;
            col_par_reg    <= '0;
            row_map_reg    <= '0;
        end
        else if (q_take)
        begin
            if (q_beat.last)
            begin
                // drop all message state once the result is formed
                crc_rem_reg    <= '0;
                checksum_reg   <= '0;
                word_shift_reg <= '0;
                bis_reg        <= '0;
                seg_idx_reg    <= '0;
                run_par_reg    <= 1'b0;
                row_par_reg    <= 1'b0;
                col_par_reg    <= '0;
                row_map_reg    <= '0;
            end
            else
            begin
                crc_rem_reg    <= crc_rem_next;
                checksum_reg   <= checksum_next;
                word_shift_reg <= word_shift_next;
                bis_reg        <= bis_next;
                seg_idx_reg    <= seg_idx_next;
                run_par_reg    <= run_par_next;
                row_par_reg    <= row_par_next;
                col_par_reg    <= col_par_next;
                row_map_reg    <= row_map_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_reg  <= '0;
            res_rd_reg  <= '0;
            res_cnt_reg <= '0;
        end
        else
        begin
            if (res_push)
            begin
                res_wr_reg <= res_wr_reg + 1'b1;
            end
            if (res_pop)
            begin
                res_rd_reg <= res_rd_reg + 1'b1;
            end
            if (res_push && !res_pop)
            begin
                res_cnt_reg <= res_cnt_reg + 1'b1;
            end
            else if (res_pop && !res_push)
            begin
                res_cnt_reg <= res_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_mem_reg[res_wr_reg] <= res_new;
        end
    end

endmodule

`default_nettype wire

@@ bench/error_detection_checker_top_test.sv @@
// Self-checking testbench for the error detection checker: table-driven and random messages.
`timescale 1ns / 1ps

module error_detection_checker_top_test;
    import edc_pkg::*;

    // Clock, reset and every block input start at a known value.
    logic                  clk     = 1'b0;
    logic                  rst_n   = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  push    = 1'b0;
    logic                  full;
    logic                  bit_req = 1'b0;
    logic                  last    = 1'b0;
    logic                  empty;
    logic                  pop     = 1'b0;
    logic                  error_found;
    logic [DATA_W-1:0]     row_errors;
    logic [DATA_W-1:0]     column_errors;
    logic [DATA_W-1:0]     check_value;

    error_detection_checker_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .bit_req       (bit_req),
        .last          (last),
        .empty         (empty),
        .pop           (pop),
        .error_found   (error_found),
        .row_errors    (row_errors),
        .column_errors (column_errors),
        .check_value   (check_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Per-message state of all four checks, kept at the block's widths.
    typedef struct packed {
        logic [31:0] crc_rem;
        logic [31:0] csum;
        logic [31:0] shift_word;
        logic [31:0] col_par;
        logic [31:0] row_map;
        logic [5:0]  bit_pos;
        logic [5:0]  seg_idx;
        logic        run_par;
        logic        row_par;
    } checker_state_t;

    // One directed message: the settings it runs under, its bits (first bit
    // at position nbits-1) and, where obvious, the report it must give.
    typedef struct {
        mode_t       mode;
        logic [5:0]  width;
        logic [4:0]  count;
        logic [32:0] divisor;
        logic [5:0]  degree;
        int          nbits;
        logic [63:0] pattern;
        bit          typed;
        result_t     want;
    } directed_row_t;

    cfg_t           regs;              // register contents as the block should hold them
    checker_state_t live_msg;          // state of the message in flight
    result_t        expected_reports[$];
    bit             frame[$];          // bits of the message being sent
    bit             steady      = 1'b0;
    bit             use_typed   = 1'b0;
    result_t        typed_report;
    int unsigned    failures    = 0;
    int unsigned    bits_sent   = 0;
    directed_row_t  plan [18];

    // Clamp a length register to 1..32, as the block treats out-of-range values.
    function automatic int unsigned clamp_len(logic [5:0] n);
        if (n == 6'd0)
        begin
            return 1;
        end
        if (n > 6'd32)
        begin
            return 32;
        end
        return n;
    endfunction

    function automatic logic [31:0] ones_below(int unsigned n);
        logic [63:0] m;
        m = (64'd1 << n) - 64'd1;
        return m[31:0];
    endfunction

    // Advance every check by one message bit under the current registers.
    function automatic checker_state_t absorb_bit(checker_state_t s, logic b);
        int unsigned w;
        int unsigned d;
        int unsigned i;
        logic [31:0] wm;
        logic [31:0] dm;
        logic [31:0] word;
        logic [32:0] total;
        logic        top;
        w  = clamp_len(regs.seg_width);
        d  = clamp_len(regs.crc_degree);
        wm = ones_below(w);
        dm = ones_below(d);
        s.run_par = s.run_par ^ b;
        // Long division: shift the bit in, subtract the divisor when the top falls out.
        top       = s.crc_rem[d-1];
        s.crc_rem = {s.crc_rem[30:0], b} & dm;
        if (top)
        begin
            s.crc_rem = s.crc_rem ^ (regs.crc_divisor[31:0] & dm);
        end
        s.shift_word = {s.shift_word[30:0], b};
        s.row_par    = s.row_par ^ b;
        s.bit_pos    = s.bit_pos + 6'd1;
        if (s.bit_pos >= w)
        begin
            // Whole row or word: fold it into the checksum with end-around carry.
            word  = s.shift_word & wm;
            total = {1'b0, s.csum & wm} + {1'b0, word};
            if (total > {1'b0, wm})
            begin
                total = (total & {1'b0, wm}) + 33'd1;
            end
            s.csum = total[31:0];
            // Only the first seg_count+1 rows touch the parity maps.
            if (s.seg_idx < regs.seg_count + 1)
            begin
                if (s.seg_idx < regs.seg_count && s.row_par)
                begin
                    s.row_map[s.seg_idx[4:0]] = 1'b1;
                end
                for (i = 0; i < w; i++)
                begin
                    if (word[w-1-i])
                    begin
                        s.col_par[i] = ~s.col_par[i];
                    end
                end
                s.seg_idx = s.seg_idx + 6'd1;
            end
            s.shift_word = '0;
            s.row_par    = 1'b0;
            s.bit_pos    = '0;
        end
        return s;
    endfunction

    // Form the report of the selected check for a message that has just closed.
    function automatic result_t report_of(checker_state_t s);
        result_t     r;
        int unsigned w;
        int unsigned d;
        w = clamp_len(regs.seg_width);
        d = clamp_len(regs.crc_degree);
        r = '0;
        case (regs.mode)
            MODE_PARITY:
            begin
                r.error_found = s.run_par;
            end
            MODE_PARITY2D:
            begin
                r.row_errors    = s.row_map;
                r.column_errors = s.col_par & ones_below(w - 1);
                r.error_found   = (r.row_errors != '0) || (r.column_errors != '0);
            end
            MODE_CHECKSUM:
            begin
                r.check_value = ~s.csum & ones_below(w);
                r.error_found = r.check_value != '0;
            end
            default:
            begin
                r.check_value = s.crc_rem & ones_below(d);
                r.error_found = r.check_value != '0;
            end
        endcase
        return r;
    endfunction

    // Take an accepted beat into the prediction; a closing beat queues a report.
    task automatic take_beat(bit b, bit closing);
        result_t r;
        live_msg = absorb_bit(live_msg, b);
        if (closing)
        begin
            r = use_typed ? typed_report : report_of(live_msg);
            expected_reports.push_back(r);
            live_msg = '0;
        end
    endtask

    // Register write over the APB port: setup cycle, then access cycle.
    // Call at a falling edge; returns at a falling edge.
    task automatic write_reg(reg_idx_t idx, logic [63:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = CFG_ADDR_W'({idx, 3'b000});
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_MODE:        regs.mode        = mode_t'(value[1:0]);
            REG_SEG_WIDTH:   regs.seg_width   = value[5:0];
            REG_SEG_COUNT:   regs.seg_count   = value[4:0];
            REG_CRC_DIVISOR: regs.crc_divisor = value[32:0];
            default:         regs.crc_degree  = value[5:0];
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Offer one bit beat and hold it until the block takes it.
    task automatic send_bit(bit b, bit closing);
        while (!steady && $urandom_range(99) < 8)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push    = 1'b1;
        bit_req = b;
        last    = closing;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        take_beat(b, closing);
        bits_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame();
        int unsigned i;
        for (i = 0; i < frame.size(); i++)
        begin
            send_bit(frame[i], i == frame.size() - 1);
        end
    endtask

    // Drop push and hold off until every report is back, then let the core settle.
    task automatic wait_idle();
        push = 1'b0;
        while (expected_reports.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    // Build a message for the current settings. A well-formed message carries
    // correct check bits for the selected mode, so the block should find no
    // error unless a bit is flipped or extra bits trail it; the rest is raw noise.
    task automatic build_frame(bit well_formed);
        checker_state_t scratch;
        int unsigned    w;
        int unsigned    d;
        int unsigned    rows;
        int unsigned    len;
        int unsigned    i;
        int unsigned    r;
        int unsigned    c;
        logic [31:0]    col;
        logic [31:0]    fix;
        bit             b;
        bit             par;
        w       = clamp_len(regs.seg_width);
        d       = clamp_len(regs.crc_degree);
        rows    = regs.seg_count + 1;
        scratch = '0;
        col     = '0;
        frame   = {};
        if (!well_formed)
        begin
            len = $urandom_range(1, rows * w + w);
            repeat (len) frame.push_back(bit'($urandom_range(1)));
        end
        else
        begin
            case (regs.mode)
                MODE_PARITY:
                begin
                    // Close on the bit that makes the overall parity even.
                    len = $urandom_range(1, 40);
                    par = 1'b0;
                    for (i = 0; i < len; i++)
                    begin
                        b   = (i == len - 1) ? par : bit'($urandom_range(1));
                        par = par ^ b;
                        frame.push_back(b);
                    end
                end
                MODE_PARITY2D:
                begin
                    // Even up each data row with its last column, then even up
                    // the checked columns with the final row.
                    for (r = 0; r < rows; r++)
                    begin
                        par = 1'b0;
                        for (c = 0; c < w; c++)
                        begin
                            b = bit'($urandom_range(1));
                            if (r < rows - 1 && c == w - 1)
                            begin
                                b = par;
                            end
                            else if (r == rows - 1 && c < w - 1)
                            begin
                                b = col[c];
                            end
                            par    = par ^ b;
                            col[c] = col[c] ^ b;
                            frame.push_back(b);
                        end
                    end
                end
                MODE_CHECKSUM:
                begin
                    // Data words, then the complement of their sum.
                    for (i = 0; i < (rows - 1) * w; i++)
                    begin
                        b       = bit'($urandom_range(1));
                        scratch = absorb_bit(scratch, b);
                        frame.push_back(b);
                    end
                    fix = ~scratch.csum & ones_below(w);
                    for (i = w; i > 0; i--)
                    begin
                        frame.push_back(fix[i-1]);
                    end
                end
                default:
                begin
                    // Data, then the remainder of the data shifted up by the degree.
                    len = $urandom_range(1, 40);
                    for (i = 0; i < len; i++)
                    begin
                        b       = bit'($urandom_range(1));
                        scratch = absorb_bit(scratch, b);
                        frame.push_back(b);
                    end
                    repeat (d) scratch = absorb_bit(scratch, 1'b0);
                    fix = scratch.crc_rem;
                    for (i = d; i > 0; i--)
                    begin
                        frame.push_back(fix[i-1]);
                    end
                end
            endcase
            // Sometimes corrupt one bit, sometimes trail extra bits.
            if ($urandom_range(2) == 0)
            begin
                i        = $urandom_range(frame.size() - 1);
                frame[i] = ~frame[i];
            end
            if ($urandom_range(3) == 0)
            begin
                repeat ($urandom_range(1, 2 * w)) frame.push_back(bit'($urandom_range(1)));
            end
        end
    endtask

    // Compare a popped report with the oldest one expected.
    task automatic check_report();
        result_t want;
        if (expected_reports.size() == 0)
        begin
            $error("report beat with no report expected");
            failures++;
        end
        else
        begin
            want = expected_reports.pop_front();
            if (error_found !== want.error_found)
            begin
                $error("error_found: expected %0h, got %0h", want.error_found, error_found);
                failures++;
            end
            if (row_errors !== want.row_errors)
            begin
                $error("row_errors: expected %h, got %h", want.row_errors, row_errors);
                failures++;
            end
            if (column_errors !== want.column_errors)
            begin
                $error("column_errors: expected %h, got %h", want.column_errors, column_errors);
                failures++;
            end
            if (check_value !== want.check_value)
            begin
                $error("check_value: expected %h, got %h", want.check_value, check_value);
                failures++;
            end
        end
    endtask

    // Report side: decide pop at the falling edge, take the beat at the rising edge.
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            pop = steady || ($urandom_range(99) >= 8);
            @(posedge clk);
            if (pop && !empty)
            begin
                check_report();
            end
        end
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Stimulus: directed table, then random phases of settings and messages.
    initial
    begin
        int unsigned k;
        int unsigned phase;
        int unsigned guard;
        int unsigned pick;
        bit          changed;
        bit          big;
        logic [63:0] noise;
        logic [5:0]  new_width;
        logic [4:0]  new_count;
        logic [5:0]  new_degree;
        logic [32:0] new_divisor;

        // Directed rows: register extremes, every mode, the special cases.
        plan[0]  = '{MODE_PARITY, 6'd8, 5'd4, CRC_DIVISOR_RST, 6'd32, 1, 64'h1, 1'b1,
                     '{1'b1, 32'h0, 32'h0, 32'h0}};
        plan[1]  = '{MODE_PARITY, 6'd8, 5'd4, CRC_DIVISOR_RST, 6'd32, 2, 64'h3, 1'b1,
                     '{1'b0, 32'h0, 32'h0, 32'h0}};
        plan[2]  = '{MODE_PARITY2D, 6'd8, 5'd4, CRC_DIVISOR_RST, 6'd32, 40, 64'h0, 1'b1,
                     '{1'b0, 32'h0, 32'h0, 32'h0}};
        plan[3]  = '{MODE_PARITY2D, 6'd1, 5'd1, CRC_DIVISOR_RST, 6'd32, 2, 64'h2, 1'b1,
                     '{1'b1, 32'h1, 32'h0, 32'h0}};
        // One full row of ones plus a trailing bit that must be ignored.
        plan[4]  = '{MODE_PARITY2D, 6'd32, 5'd31, CRC_DIVISOR_RST, 6'd32, 33,
                     64'h1_FFFF_FFFF, 1'b1, '{1'b1, 32'h0, 32'h7FFF_FFFF, 32'h0}};
        // Rows beyond the first seg_count+1 must not touch the parity maps.
        plan[5]  = '{MODE_PARITY2D, 6'd2, 5'd1, CRC_DIVISOR_RST, 6'd32, 8, 64'h6D, 1'b0,
                     '{1'b0, 32'h0, 32'h0, 32'h0}};
        plan[6]  = '{MODE_PARITY2D, 6'd0, 5'd0, CRC_DIVISOR_RST, 6'd32, 3, 64'h5, 1'b0,
                     '{1'b0, 32'h0, 32'h0, 32'h0}};
        plan[7]  = '{MODE_CHECKSUM, 6'd4, 5'd1, CRC_DIVISOR_RST, 6'd32, 8, 64'hF0, 1'b1,
                     '{1'b0, 32'h0, 32'h0, 32'h0}};
        // End-around carry: 9 + 9 folds to 3, complement C.
        plan[8]  = '{MODE_CHECKSUM, 6'd4, 5'd1, CRC_DIVISOR_RST, 6'd32, 8, 64'h99, 1'b1,
                     '{1'b1, 32'h0, 32'h0, 32'hC}};
        // No whole word at all.
        plan[9]  = '{MODE_CHECKSUM, 6'd8, 5'd4, CRC_DIVISOR_RST, 6'd32, 1, 64'h1, 1'b1,
                     '{1'b1, 32'h0, 32'h0, 32'hFF}};
        plan[10] = '{MODE_CHECKSUM, 6'd63, 5'd0, CRC_DIVISOR_RST, 6'd32, 64,
                     64'hDEAD_BEEF_1234_5678, 1'b0, '{1'b0, 32'h0, 32'h0, 32'h0}};
        // Message shorter than the degree comes back as its own remainder.
        plan[11] = '{MODE_CRC, 6'd63, 5'd0, CRC_DIVISOR_RST, 6'd32, 3, 64'h5, 1'b1,
                     '{1'b1, 32'h0, 32'h0, 32'h5}};
        plan[12] = '{MODE_CRC, 6'd63, 5'd0, 33'h0, 6'd1, 5, 64'h16, 1'b0,
                     '{1'b0, 32'h0, 32'h0, 32'h0}};
        plan[13] = '{MODE_CRC, 6'd63, 5'd0, 33'h1_FFFF_FFFF, 6'd0, 4, 64'hB, 1'b0,
                     '{1'b0, 32'h0, 32'h0, 32'h0}};
        plan[14] = '{MODE_CRC, 6'd63, 5'd0, 33'h1_FFFF_FFFF, 6'd63, 64,
                     64'h0123_4567_89AB_CDEF, 1'b0, '{1'b0, 32'h0, 32'h0, 32'h0}};
        plan[15] = '{MODE_CRC, 6'd63, 5'd0, 33'h107, 6'd8, 16, 64'hA5C3, 1'b0,
                     '{1'b0, 32'h0, 32'h0, 32'h0}};
        plan[16] = '{MODE_CRC, 6'd63, 5'd0, 33'h107, 6'd8, 16, 64'h0, 1'b1,
                     '{1'b0, 32'h0, 32'h0, 32'h0}};
        // Leading divisor bit clear: still taken as one.
        plan[17] = '{MODE_CRC, 6'd63, 5'd0, 33'h0_04C1_1DB7, 6'd32, 40,
                     64'hC3_5A5A_0F0F, 1'b0, '{1'b0, 32'h0, 32'h0, 32'h0}};

        regs.mode        = MODE_PARITY;
        regs.seg_width   = SEG_WIDTH_RST;
        regs.seg_count   = SEG_COUNT_RST;
        regs.crc_divisor = CRC_DIVISOR_RST;
        regs.crc_degree  = CRC_DEGREE_RST;
        live_msg         = '0;

        // Hold reset, then release it away from the rising edge.
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the table; rewrite only the registers a row changes, and only
        // once every report of the previous setting is back.
        for (k = 0; k < 18; k++)
        begin
            changed = (regs.mode != plan[k].mode) || (regs.seg_width != plan[k].width)
                   || (regs.seg_count != plan[k].count)
                   || (regs.crc_divisor != plan[k].divisor)
                   || (regs.crc_degree != plan[k].degree);
            if (changed)
            begin
                wait_idle();
                if (regs.mode != plan[k].mode)
                begin
                    write_reg(REG_MODE, 64'(plan[k].mode));
                end
                if (regs.seg_width != plan[k].width)
                begin
                    write_reg(REG_SEG_WIDTH, 64'(plan[k].width));
                end
                if (regs.seg_count != plan[k].count)
                begin
                    write_reg(REG_SEG_COUNT, 64'(plan[k].count));
                end
                if (regs.crc_divisor != plan[k].divisor)
                begin
                    write_reg(REG_CRC_DIVISOR, 64'(plan[k].divisor));
                end
                if (regs.crc_degree != plan[k].degree)
                begin
                    write_reg(REG_CRC_DEGREE, 64'(plan[k].degree));
                end
            end
            frame = {};
            for (int j = plan[k].nbits - 1; j >= 0; j--)
            begin
                frame.push_back(plan[k].pattern[j]);
            end
            use_typed    = plan[k].typed;
            typed_report = plan[k].want;
            send_frame();
            use_typed    = 1'b0;
        end

        // Random phases: fresh settings each phase, then a burst of messages (only one in a big phase).
        // Phases four to seven run with no idling on either side.
        phase     = 0;
        while (bits_sent < 2000)
        begin
            wait_idle();
            steady = (phase >= 4) && (phase < 8);
            big    = (phase == 1) || ($urandom_range(11) == 0);

            pick = $urandom_range(19);
            if (big)
            begin
                new_width = 6'd32;
            end
            else if (pick == 0)
            begin
                new_width = 6'd0;
            end
            else if (pick == 1)
            begin
                new_width = 6'($urandom_range(33, 63));
            end
            else if (pick == 2)
            begin
                new_width = 6'd32;
            end
            else
            begin
                new_width = 6'($urandom_range(1, 12));
            end

            if (big)
            begin
                new_count = 5'd31;
            end
            else if (clamp_len(new_width) <= 4 && $urandom_range(9) == 0)
            begin
                new_count = 5'd31;
            end
            else
            begin
                new_count = 5'($urandom_range(0, 6));
            end

            pick = $urandom_range(9);
            if (pick == 0)
            begin
                new_degree = 6'd0;
            end
            else if (pick == 1)
            begin
                new_degree = 6'($urandom_range(33, 63));
            end
            else if (pick == 2)
            begin
                new_degree = 6'd32;
            end
            else
            begin
                new_degree = 6'($urandom_range(1, 31));
            end

            new_divisor = ($urandom_range(7) == 0) ? CRC_DIVISOR_RST
                                                   : {1'($urandom_range(1)), $urandom};

            // Now and then fill the unused upper data bits with junk.
            noise = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'd0;
            write_reg(REG_MODE,        {noise[63:2], 2'($urandom_range(3))});
            write_reg(REG_SEG_WIDTH,   {noise[63:6], new_width});
            write_reg(REG_SEG_COUNT,   {noise[63:5], new_count});
            write_reg(REG_CRC_DIVISOR, {noise[63:33], new_divisor});
            write_reg(REG_CRC_DEGREE,  {noise[63:6], new_degree});

            repeat (big ? 1 : $urandom_range(3, 8))
            begin
                build_frame($urandom_range(3) != 0);
                send_frame();
                // Occasionally hold the sender until every report is in.
                if ($urandom_range(9) == 0)
                begin
                    wait_idle();
                end
            end
            phase++;
        end

        // Drain: wait for the outstanding reports, bounded, then let the core settle.
        steady = 1'b0;
        push   = 1'b0;
        guard  = 0;
        while (expected_reports.size() != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (10) @(negedge clk);
        if (expected_reports.size() != 0)
        begin
            $error("%0d expected reports never arrived", expected_reports.size());
            failures++;
        end
        if (failures == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
